[hdl/trbc_pkg.sv]
// Package: shared constants and tables for triangle rotation about box center.
`default_nettype none
package trbc_pkg;
  localparam int CordicSteps = 24;
  localparam logic signed [31:0] CordicGain = 32'sd652032874;
  localparam logic signed [15:0] FullTurn = 16'sd23040;
  localparam logic signed [15:0] HalfTurn = 16'sd11520;
  localparam logic signed [15:0] QuarterTurn = 16'sd5760;

  function automatic logic [21:0] atan_deg16(input logic [4:0] i);
    logic [21:0] r;
    begin
      case (i)
        5'd0: r = 22'd2949120;
        5'd1: r = 22'd1740967;
        5'd2: r = 22'd919879;
        5'd3: r = 22'd466945;
        5'd4: r = 22'd234379;
        5'd5: r = 22'd117304;
        5'd6: r = 22'd58666;
        5'd7: r = 22'd29335;
        5'd8: r = 22'd14668;
        5'd9: r = 22'd7334;
        5'd10: r = 22'd3667;
        5'd11: r = 22'd1833;
        5'd12: r = 22'd917;
        5'd13: r = 22'd458;
        5'd14: r = 22'd229;
        5'd15: r = 22'd115;
        5'd16: r = 22'd57;
        5'd17: r = 22'd29;
        5'd18: r = 22'd14;
        5'd19: r = 22'd7;
        5'd20: r = 22'd4;
        5'd21: r = 22'd2;
        5'd22: r = 22'd1;
        5'd23: r = 22'd1;
        default: r = 22'd0;
      endcase
      return r;
    end
  endfunction
endpackage
`default_nettype wire

[hdl/triangle_rotate_about_box_center.sv]
// Top level: pipelined rotation of a triangle about its bounding-box center.
// Usage:
//   s_axis carries one triangle per request in s_axis_tdata:
//   bits from low: a_x, a_y, b_x, b_y, c_x, c_y (24 bit each), angle (16 bit).
//   m_axis returns the three rotated vertices in m_axis_tdata, same order.
//   Stage 0 reduces the angle and forms the box sums and offsets; stages
//   1..24 run one CORDIC step each; then two product stages (partials,
//   sums), one rounding/saturation stage. Throughput is one triangle per
//   cycle while m_axis_tready does not stall the pipe.
//   The pipe advances whenever the output register is empty or taken, so a
//   stall of m_axis_tready holds every stage and loses nothing; s_axis_tready
//   follows that advance signal.
//   rst (synchronous) clears all valid bits; payload registers are not reset.
`default_nettype none
module triangle_rotate_about_box_center (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // a_x, a_y, b_x, b_y, c_x, c_y, rotation_angle
  input  wire logic [159:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // rotated_a_x, rotated_a_y, rotated_b_x, rotated_b_y, rotated_c_x, rotated_c_y
  output logic [143:0]      m_axis_tdata
);
  import trbc_pkg::*;

  localparam int NS = CordicSteps;
  localparam int L = NS + 4;

  logic adv;
  logic [L-1:0] vld;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld[L-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[L-2:0], s_axis_tvalid};
  end

  // stage 0 combinational
  logic signed [23:0] vx [3];
  logic signed [23:0] vy [3];
  logic signed [15:0] ang;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vx[k] = s_axis_tdata[48*k +: 24];
      vy[k] = s_axis_tdata[48*k+24 +: 24];
    end
    ang = s_axis_tdata[159:144];
  end

  logic signed [16:0] r0, r1;
  logic neg0;
  always_comb begin
    // one turn at most away from [-180, 180) over the whole input range
    r0 = 17'(ang);
    if (r0 >= 17'(HalfTurn)) r0 = r0 - 17'(FullTurn);
    else if (r0 < -17'(HalfTurn)) r0 = r0 + 17'(FullTurn);
    neg0 = 1'b0;
    r1 = r0;
    if (r0 > 17'(QuarterTurn)) begin
      r1 = r0 - 17'(HalfTurn);
      neg0 = 1'b1;
    end else if (r0 < -17'(QuarterTurn)) begin
      r1 = r0 + 17'(HalfTurn);
      neg0 = 1'b1;
    end
  end

  function automatic logic signed [24:0] mn3(input logic signed [23:0] a, b, c);
    logic signed [23:0] m;
    begin
      m = (a < b) ? a : b;
      m = (m < c) ? m : c;
      return 25'(m);
    end
  endfunction
  function automatic logic signed [24:0] mx3(input logic signed [23:0] a, b, c);
    logic signed [23:0] m;
    begin
      m = (a > b) ? a : b;
      m = (m > c) ? m : c;
      return 25'(m);
    end
  endfunction

  logic signed [24:0] sx0, sy0;
  assign sx0 = mn3(vx[0], vx[1], vx[2]) + mx3(vx[0], vx[1], vx[2]);
  assign sy0 = mn3(vy[0], vy[1], vy[2]) + mx3(vy[0], vy[1], vy[2]);

  // CORDIC pipeline and payload carriers
  logic signed [31:0] cx [NS+1];
  logic signed [31:0] cy [NS+1];
  logic signed [24:0] cz [NS+1];
  logic neg [NS+1];
  logic signed [24:0] psx [NS+1];
  logic signed [24:0] psy [NS+1];
  logic signed [25:0] pdx [NS+1][3];
  logic signed [25:0] pdy [NS+1][3];

  always_ff @(posedge clk) begin
    if (adv) begin
      cx[0] <= CordicGain;
      cy[0] <= '0;
      cz[0] <= 25'(r1) * 25'sd1024;
      neg[0] <= neg0;
      psx[0] <= sx0;
      psy[0] <= sy0;
      for (int k = 0; k < 3; k++) begin
        pdx[0][k] <= 26'(vx[k]) * 26'sd2 - 26'(sx0);
        pdy[0][k] <= 26'(vy[k]) * 26'sd2 - 26'(sy0);
      end
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_cordic
    logic signed [31:0] xs, ys;
    logic signed [24:0] at;
    assign xs = cx[i] >>> i;
    assign ys = cy[i] >>> i;
    assign at = 25'(atan_deg16(5'(i)));
    always_ff @(posedge clk) begin
      if (adv) begin
        if (cz[i] >= 0) begin
          cx[i+1] <= cx[i] - ys;
          cy[i+1] <= cy[i] + xs;
          cz[i+1] <= cz[i] - at;
        end else begin
          cx[i+1] <= cx[i] + ys;
          cy[i+1] <= cy[i] - xs;
          cz[i+1] <= cz[i] + at;
        end
        neg[i+1] <= neg[i];
        psx[i+1] <= psx[i];
        psy[i+1] <= psy[i];
        pdx[i+1] <= pdx[i];
        pdy[i+1] <= pdy[i];
      end
    end
  end

  // product stage
  logic signed [31:0] cosv, sinv;
  assign cosv = neg[NS] ? -cx[NS] : cx[NS];
  assign sinv = neg[NS] ? -cy[NS] : cy[NS];
  logic signed [57:0] pxc [3], pxs [3], pyc [3], pys [3];
  logic signed [24:0] qsx, qsy;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        pxc[k] <= 58'(pdx[NS][k]) * 58'(cosv);
        pxs[k] <= 58'(pdx[NS][k]) * 58'(sinv);
        pyc[k] <= 58'(pdy[NS][k]) * 58'(cosv);
        pys[k] <= 58'(pdy[NS][k]) * 58'(sinv);
      end
      qsx <= psx[NS];
      qsy <= psy[NS];
    end
  end

  // sum stage
  logic signed [59:0] rx [3], ry [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        rx[k] <= (60'(qsx) <<< 30) + 60'(pxc[k]) - 60'(pys[k]) + (60'sd1 <<< 30);
        ry[k] <= (60'(qsy) <<< 30) + 60'(pxs[k]) + 60'(pyc[k]) + (60'sd1 <<< 30);
      end
    end
  end

  function automatic logic [23:0] sat(input logic signed [59:0] v);
    logic signed [28:0] t;
    begin
      t = 29'(v >>> 31);
      if (t > 29'sd8388607) return 24'h7FFFFF;
      else if (t < -29'sd8388608) return 24'h800000;
      else return t[23:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        m_axis_tdata[48*k +: 24] <= sat(rx[k]);
        m_axis_tdata[48*k+24 +: 24] <= sat(ry[k]);
      end
    end
  end
endmodule
`default_nettype wire
